@@ design/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and controller/datapath interface types for the QRS
// beat detector.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int LP_DELAY = 11;
  localparam int HP_DELAY = 29;
  localparam int WIN_LEN  = 54;

  localparam int LP_SIZE  = 2 * LP_DELAY + 1;
  localparam int HP_SIZE  = 2 * HP_DELAY + 1;

  // High-pass divide by 2*HP_DELAY: reciprocal multiply plus one correction
  localparam int HP_DIV   = 2 * HP_DELAY;
  localparam int HP_SHIFT = 31 + $clog2(HP_DIV);
  localparam logic [31:0] HP_RECIP = 32'((64'd1 << HP_SHIFT) / HP_DIV);

  localparam int SUM_W     = 56;
  localparam int E_W       = 48;
  localparam int WIN_REM_W = $clog2(WIN_LEN);
  localparam int AVG_BITS  = 4;
  localparam int AVG_STEPS = SUM_W / AVG_BITS;
  localparam int RATE_STEPS = 8;
  localparam int CNT_W = $clog2((AVG_STEPS > RATE_STEPS) ? AVG_STEPS : RATE_STEPS);

  localparam logic [16:0]    DC_POLE   = 17'd65208;
  localparam logic [E_W-1:0] E_MAX     = {E_W{1'b1}};
  localparam logic [E_W-1:0] THR_RESET = E_W'(1000) << 16;
  localparam logic [E_W-1:0] SIG_RESET = E_W'(2000) << 16;

  localparam logic [9:0]  REFR_RESET    = 10'd72;
  localparam logic [15:0] TIMEOUT_RESET = 16'd720;
  localparam logic [10:0] FS_RESET      = 11'd360;

  localparam logic [1:0] CFG_REFRACTORY = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd1;
  localparam logic [1:0] CFG_RATE       = 2'd2;

  typedef struct packed {
    logic load;
    logic dc;
    logic lp;
    logic div_a;
    logic div_b;
    logic hp;
    logic slope;
    logic square;
    logic avg;
    logic peak;
    logic thresh;
    logic rate_load;
    logic rate_step;
    logic decay;
    logic emit;
  } qrs_cmd_t;

  typedef struct packed {
    logic is_peak;
    logic rate_go;
    logic out_free;
  } qrs_stat_t;

endpackage

@@ design/qrs_beat_detector_top.sv @@
// ----------------------------------------------------------------------------
// qrs_beat_detector_top
// QRS beat detector: band-pass, slope, energy window and adaptive peak
// classification with a smoothed heart rate, one result beat per sample.
// ----------------------------------------------------------------------------
// Each accepted sample beat yields one result beat {heart_rate, beat}. A
// sample passes through the filters and the divide of the window sum (4
// quotient bits a cycle), and through the rate division when a beat also
// updates the heart rate; one shared multiplier serves the DC filter, the
// high-pass divides, the squaring and the rate product. The next sample
// is taken once the previous one has been written to the output register,
// even while that result still waits for m_tready. Configuration writes are
// always accepted; register 0 is the refractory period, 1 the no-beat
// timeout and 2 the sample rate, and other indexes are ignored.
module qrs_beat_detector_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] beat, [8:1] heart_rate
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import qrs_pkg::*;

  qrs_cmd_t  cmd;
  qrs_stat_t stat;
  logic       beat_out;
  logic [7:0] rate_out;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'b0, rate_out, beat_out};

  qrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  qrs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample    (s_tdata[11:0]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .beat_out  (beat_out),
    .rate_out  (rate_out)
  );

endmodule

@@ design/qrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// qrs_ctrl
// Sequencer that steps one sample through the detector datapath.
// ----------------------------------------------------------------------------
module qrs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output qrs_pkg::qrs_cmd_t  cmd,
  input  qrs_pkg::qrs_stat_t stat
);
  import qrs_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DC    = 4'd1;
  localparam logic [3:0] ST_LP    = 4'd2;
  localparam logic [3:0] ST_DIVA  = 4'd3;
  localparam logic [3:0] ST_DIVB  = 4'd4;
  localparam logic [3:0] ST_HP    = 4'd5;
  localparam logic [3:0] ST_SLOPE = 4'd6;
  localparam logic [3:0] ST_SQ    = 4'd7;
  localparam logic [3:0] ST_AVG   = 4'd8;
  localparam logic [3:0] ST_PEAK  = 4'd9;
  localparam logic [3:0] ST_THR   = 4'd10;
  localparam logic [3:0] ST_RLOAD = 4'd11;
  localparam logic [3:0] ST_RDIV  = 4'd12;
  localparam logic [3:0] ST_DECAY = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    s_tready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DC;
        end
      end
      ST_DC: begin
        cmd.dc     = 1'b1;
        state_next = ST_LP;
      end
      ST_LP: begin
        cmd.lp     = 1'b1;
        state_next = ST_DIVA;
      end
      ST_DIVA: begin
        cmd.div_a  = 1'b1;
        state_next = ST_DIVB;
      end
      ST_DIVB: begin
        cmd.div_b  = 1'b1;
        state_next = ST_HP;
      end
      ST_HP: begin
        cmd.hp     = 1'b1;
        state_next = ST_SLOPE;
      end
      ST_SLOPE: begin
        cmd.slope  = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        cnt_next   = '0;
        state_next = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg = 1'b1;
        if (cnt == CNT_W'(AVG_STEPS - 1)) begin
          state_next = ST_PEAK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PEAK: begin
        cmd.peak   = 1'b1;
        state_next = stat.is_peak ? ST_THR : ST_DECAY;
      end
      ST_THR: begin
        cmd.thresh = 1'b1;
        state_next = stat.rate_go ? ST_RLOAD : ST_DECAY;
      end
      ST_RLOAD: begin
        cmd.rate_load = 1'b1;
        cnt_next      = '0;
        state_next    = ST_RDIV;
      end
      ST_RDIV: begin
        cmd.rate_step = 1'b1;
        if (cnt == CNT_W'(RATE_STEPS - 1)) begin
          state_next = ST_DECAY;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DECAY: begin
        cmd.decay  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/qrs_dp.sv @@
// ----------------------------------------------------------------------------
// qrs_dp
// Filter chain, energy window, peak classification and rate arithmetic,
// driven one step at a time by the sequencer.
// ----------------------------------------------------------------------------
module qrs_dp (
  input  logic               clk,
  input  logic               rst,
  input  qrs_pkg::qrs_cmd_t  cmd,
  output qrs_pkg::qrs_stat_t stat,
  input  logic [11:0]        sample,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic               beat_out,
  output logic [7:0]         rate_out
);
  import qrs_pkg::*;

  localparam logic signed [35:0] S32_MAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] S32_MIN = 36'shF80000000;

  // configuration
  logic [9:0]  refr;
  logic [15:0] tmo;
  logic [10:0] fs;

  // state cleared at reset
  logic signed [19:0] x1;
  logic signed [31:0] y1;
  logic [31:0]        lp_h [LP_SIZE];
  logic [31:0]        lpo1, lpo2;
  logic [31:0]        hp_h [HP_SIZE];
  logic [31:0]        hpo1;
  logic [31:0]        taps [5];
  logic [E_W-1:0]     win  [WIN_LEN];
  logic [SUM_W-1:0]   sum;
  logic [E_W-1:0]     lvl1, lvl2, thr, sig, noise;
  logic [31:0]        tick, lbt, ldt;
  logic [7:0]         rate;
  logic               beat, rate_go;

  // working registers
  logic signed [19:0]  x;
  logic signed [65:0]  prod;
  logic [31:0]         qa;
  logic                sq_big;
  logic [SUM_W-1:0]    dq;
  logic [WIN_REM_W-1:0] rem;
  logic [31:0]         dur_r;
  logic [43:0]         rn, dsh;
  logic [7:0]          rq;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // quotient toward zero of a signed value by HP_DIV from its reciprocal product
  function automatic logic [31:0] hp_quot(input logic [31:0] v, input logic [65:0] pq);
    logic [31:0] av;
    logic [31:0] q0;
    logic [37:0] rr;
    av = abs32(v);
    q0 = 32'(pq[63:0] >> HP_SHIFT);
    rr = 38'(av) - 38'(q0) * 38'(HP_DIV);
    if (rr >= 38'(HP_DIV)) q0 = q0 + 32'd1;
    return v[31] ? (~q0 + 32'd1) : q0;
  endfunction

  function automatic logic [E_W-1:0] avg8(input logic [E_W-1:0] p, input logic [E_W-1:0] l);
    logic [E_W+2:0] s;
    s = ({3'b0, l} << 3) - {3'b0, l} + {3'b0, p} + (E_W+3)'(4);
    return s[E_W+2:3];
  endfunction

  function automatic logic [E_W-1:0] thr_of(input logic [E_W-1:0] n, input logic [E_W-1:0] s);
    logic [E_W+1:0] t;
    t = ({2'b0, n} << 1) + {2'b0, n} + {2'b0, s} + (E_W+2)'(2);
    return t[E_W+1:2];
  endfunction

  // combinational terms
  logic signed [49:0] dc_rnd, dc_fl;
  logic signed [35:0] dc_sum;
  logic [31:0]        dc_val, lp_val, hp_val;
  logic [31:0]        av_a, av_b;
  logic signed [34:0] slope_d;
  logic [34:0]        mag;
  logic [64:0]        sq_r, sq_sh;
  logic [E_W-1:0]     sq_val;
  logic [SUM_W-1:0]   sum_next;
  logic [WIN_REM_W:0] ar_t;
  logic [WIN_REM_W-1:0] ar_r;
  logic [SUM_W-1:0]   ar_d;
  logic [E_W-1:0]     cur;
  logic [31:0]        cand_tick, dur;
  logic               is_peak, take;
  logic [16:0]        num;
  logic [39:0]        d40, d200;
  logic               rate_ok;
  logic [43:0]        rate_n;
  logic [35:0]        d10;
  logic signed [32:0] ma, mb;
  logic               mul_en;

  always_comb begin
    dc_rnd = prod[49:0] + 50'sd32768;
    dc_fl  = dc_rnd >>> 16;
    dc_sum = 36'(dc_fl) + 36'(x) - 36'(x1);
    if (dc_sum > S32_MAX) dc_val = 32'h7FFFFFFF;
    else if (dc_sum < S32_MIN) dc_val = 32'h80000000;
    else dc_val = dc_sum[31:0];

    lp_val = (lpo1 << 1) - lpo2 + lp_h[0] - (lp_h[LP_DELAY] << 1) + lp_h[2 * LP_DELAY];

    av_a   = abs32(hp_h[0]);
    av_b   = abs32(hp_h[HP_SIZE-1]);
    hp_val = hpo1 - qa + hp_h[HP_DELAY] - hp_h[HP_DELAY+1] + hp_quot(hp_h[HP_SIZE-1], prod);

    slope_d = (35'(signed'(taps[0])) <<< 1) + 35'(signed'(taps[1]))
            - 35'(signed'(taps[3])) - (35'(signed'(taps[4])) <<< 1);
    mag     = slope_d[34] ? 35'(-slope_d) : 35'(slope_d);

    sq_r   = {1'b0, prod[63:0]} + 65'd32;
    sq_sh  = sq_r >> 6;
    sq_val = (sq_big || (|sq_sh[64:E_W])) ? E_MAX : sq_sh[E_W-1:0];
    sum_next = sum - SUM_W'(win[WIN_LEN-1]) + SUM_W'(sq_val);

    // window divide: AVG_BITS quotient bits per step
    ar_r = rem;
    ar_d = dq;
    for (int i = 0; i < AVG_BITS; i++) begin
      ar_t = {ar_r, ar_d[SUM_W-1]};
      ar_d = ar_d << 1;
      if (ar_t >= (WIN_REM_W+1)'(WIN_LEN)) begin
        ar_r    = WIN_REM_W'(ar_t - (WIN_REM_W+1)'(WIN_LEN));
        ar_d[0] = 1'b1;
      end else begin
        ar_r = ar_t[WIN_REM_W-1:0];
      end
    end

    cur       = dq[E_W-1:0];
    cand_tick = tick - 32'd1;
    dur       = cand_tick - lbt;
    is_peak   = (lvl1 > lvl2) && (lvl1 > cur);
    take      = is_peak && (dur > {22'b0, refr}) && (lvl1 > thr);
    num       = 17'({fs, 6'b0}) - 17'({fs, 2'b0});
    d40       = (40'(dur) << 5) + (40'(dur) << 3);
    d200      = (40'(dur) << 7) + (40'(dur) << 6) + (40'(dur) << 3);
    rate_ok   = (40'(num) > d40) && (40'(num) < d200);

    rate_n = (44'(prod[39:0]) << 3) + 44'(prod[39:0]) + 44'(num);
    d10    = (36'(dur_r) << 3) + (36'(dur_r) << 1);

    mul_en = cmd.load | cmd.div_a | cmd.div_b | cmd.slope | cmd.peak;
    ma = '0;
    mb = '0;
    if (cmd.load) begin
      ma = 33'(y1);
      mb = {16'b0, DC_POLE};
    end else if (cmd.div_a) begin
      ma = {1'b0, av_a};
      mb = {1'b0, HP_RECIP};
    end else if (cmd.div_b) begin
      ma = {1'b0, av_b};
      mb = {1'b0, HP_RECIP};
    end else if (cmd.slope) begin
      ma = {1'b0, mag[31:0]};
      mb = {1'b0, mag[31:0]};
    end else if (cmd.peak) begin
      ma = {25'b0, rate};
      mb = {1'b0, dur};
    end
  end

  assign stat.is_peak  = is_peak;
  assign stat.rate_go  = rate_go;
  assign stat.out_free = !m_tvalid || m_tready;

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (mul_en) prod <= ma * mb;
    if (cmd.load) x <= {~sample[11], sample[10:0], 8'b0};
    if (cmd.div_b) qa <= hp_quot(hp_h[0], prod);
    if (cmd.slope) sq_big <= |mag[34:32];
    if (cmd.square) begin
      dq  <= sum_next;
      rem <= '0;
    end
    if (cmd.avg) begin
      dq  <= ar_d;
      rem <= ar_r;
    end
    if (cmd.peak) dur_r <= dur;
    if (cmd.rate_load) begin
      rn  <= rate_n;
      dsh <= 44'(d10) << (RATE_STEPS - 1);
      rq  <= '0;
    end
    if (cmd.rate_step) begin
      if (rn >= dsh) begin
        rn <= rn - dsh;
        rq <= {rq[6:0], 1'b1};
      end else begin
        rq <= {rq[6:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.emit) begin
      beat_out <= beat;
      rate_out <= rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refr  <= REFR_RESET;
      tmo   <= TIMEOUT_RESET;
      fs    <= FS_RESET;
      x1    <= '0;
      y1    <= '0;
      for (int i = 0; i < LP_SIZE; i++) lp_h[i] <= '0;
      lpo1  <= '0;
      lpo2  <= '0;
      for (int i = 0; i < HP_SIZE; i++) hp_h[i] <= '0;
      hpo1  <= '0;
      for (int i = 0; i < 5; i++) taps[i] <= '0;
      for (int i = 0; i < WIN_LEN; i++) win[i] <= '0;
      sum   <= '0;
      lvl1  <= '0;
      lvl2  <= '0;
      thr   <= THR_RESET;
      sig   <= SIG_RESET;
      noise <= '0;
      tick  <= '0;
      lbt   <= '0;
      ldt   <= '0;
      rate  <= '0;
      beat  <= 1'b0;
      rate_go  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_REFRACTORY: refr <= cfg_data[9:0];
          CFG_TIMEOUT:    tmo  <= cfg_data;
          CFG_RATE:       fs   <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        tick <= tick + 32'd1;
        beat <= 1'b0;
      end
      if (cmd.dc) begin
        x1 <= x;
        y1 <= dc_val;
        lp_h[0] <= dc_val;
        for (int i = 1; i < LP_SIZE; i++) lp_h[i] <= lp_h[i-1];
      end
      if (cmd.lp) begin
        lpo2 <= lpo1;
        lpo1 <= lp_val;
        hp_h[0] <= lp_val;
        for (int i = 1; i < HP_SIZE; i++) hp_h[i] <= hp_h[i-1];
      end
      if (cmd.hp) begin
        hpo1 <= hp_val;
        taps[0] <= hp_val;
        for (int i = 1; i < 5; i++) taps[i] <= taps[i-1];
      end
      if (cmd.square) begin
        sum <= sum_next;
        win[0] <= sq_val;
        for (int i = 1; i < WIN_LEN; i++) win[i] <= win[i-1];
      end
      if (cmd.peak) begin
        rate_go <= take && rate_ok;
        if (take) begin
          sig  <= avg8(lvl1, sig);
          beat <= 1'b1;
          lbt  <= cand_tick;
        end else if (is_peak) begin
          noise <= avg8(lvl1, noise);
        end
      end
      if (cmd.thresh) thr <= thr_of(noise, sig);
      if (cmd.decay) begin
        if ((tick - lbt) > {16'b0, tmo}) begin
          if ((tick - ldt) > {21'b0, fs}) begin
            thr <= thr >> 1;
            ldt <= tick;
          end
        end else begin
          ldt <= tick;
        end
        lvl2 <= lvl1;
        lvl1 <= cur;
        if (rate_go) rate <= rq;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
